>>> src/cpq_pkg.sv
package cpq_pkg;

   // Item kinds carried in the func field of an input word.
   typedef enum logic [1:0] {
      FUNC_COIN   = 2'd0,
      FUNC_PRIZE  = 2'd1,
      FUNC_TICK   = 2'd2,
      FUNC_CREDIT = 2'd3
   } func_type;

   // Configuration register indexes.
   localparam int unsigned CSR_INDEX_W = 3;
   localparam logic [CSR_INDEX_W-1:0] CSR_COIN_IDLE  = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_PRIZE_IDLE = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_COIN_MIN   = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_COIN_MAX   = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_PRIZE_MIN  = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_PRIZE_MAX  = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] CSR_HACK_GAP   = 3'd6;

   localparam int unsigned CSR_DATA_W = 16;
   localparam int unsigned TIME_W     = 32;
   localparam int unsigned COUNT_W    = 32;
   localparam int unsigned PEND_W     = 16;
   localparam int unsigned CREDIT_W   = 8;

   localparam logic [PEND_W-1:0] PENDING_MAX = {PEND_W{1'b1}};
   localparam logic [1:0] HACKS_PER_ALERT = 2'd3;

   // Reset values of the configuration registers.
   localparam logic [CSR_DATA_W-1:0] RST_WIDTH_MIN = 16'd20;
   localparam logic [CSR_DATA_W-1:0] RST_WIDTH_MAX = 16'd120;
   localparam logic [CSR_DATA_W-1:0] RST_HACK_GAP  = 16'd60;

   typedef struct packed {
      logic                  coin_idle;
      logic                  prize_idle;
      logic [CSR_DATA_W-1:0] coin_min;
      logic [CSR_DATA_W-1:0] coin_max;
      logic [CSR_DATA_W-1:0] prize_min;
      logic [CSR_DATA_W-1:0] prize_max;
      logic [CSR_DATA_W-1:0] hack_gap;
   } cfg_type;

endpackage

>>> src/cpq_csr.sv
module cpq_csr (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_valid,
   input  logic [cpq_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  logic [cpq_pkg::CSR_DATA_W-1:0]       csr_wdata,
   output cpq_pkg::cfg_type                     cfg
);
   import cpq_pkg::*;

   cfg_type cfg_ff, cfg_in;

   // Writes to an index outside the register list fall through unchanged.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_COIN_IDLE:  cfg_in.coin_idle  = csr_wdata[0];
            CSR_PRIZE_IDLE: cfg_in.prize_idle = csr_wdata[0];
            CSR_COIN_MIN:   cfg_in.coin_min   = csr_wdata;
            CSR_COIN_MAX:   cfg_in.coin_max   = csr_wdata;
            CSR_PRIZE_MIN:  cfg_in.prize_min  = csr_wdata;
            CSR_PRIZE_MAX:  cfg_in.prize_max  = csr_wdata;
            CSR_HACK_GAP:   cfg_in.hack_gap   = csr_wdata;
            default:        cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.coin_idle  <= 1'b1;
         cfg_ff.prize_idle <= 1'b1;
         cfg_ff.coin_min   <= RST_WIDTH_MIN;
         cfg_ff.coin_max   <= RST_WIDTH_MAX;
         cfg_ff.prize_min  <= RST_WIDTH_MIN;
         cfg_ff.prize_max  <= RST_WIDTH_MAX;
         cfg_ff.hack_gap   <= RST_HACK_GAP;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

>>> src/coin_pulse_qualifier.sv
// Coin and prize pulse qualifier.
//
// The req_ channel carries one word per event: a coin or prize pin sample with its
// millisecond timestamp, an output timer tick, or an add-credit request. The rsp_
// channel returns exactly one word per request word, holding the running totals,
// the per-word accept and alert flags, both output pin levels and the number of
// output toggles still queued. The csr_ channel writes the seven configuration
// registers; it is always ready and should only be written while the block is idle.
//
// A request word is captured in an input register, qualified by one level of
// compare-and-count logic and written into the response register once that
// register is empty or being read. One word per cycle is sustained while the
// receiver keeps rsp_ready high; the rate is set by the single update of the
// event state per cycle.
// When the receiver stalls, the response register holds its word and the input
// register holds the next one; req_ready drops only once both are occupied.
// A synchronous reset empties both registers, clears all counters, timestamps,
// last levels and output pins, and restores the configuration defaults.
module coin_pulse_qualifier (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic [1:0]                           req_func,
   input  logic                                 req_pin_level,
   input  logic [cpq_pkg::TIME_W-1:0]           req_now_ms,
   input  logic [cpq_pkg::CREDIT_W-1:0]         req_credit_count,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic [cpq_pkg::COUNT_W-1:0]          rsp_coin_total,
   output logic [cpq_pkg::COUNT_W-1:0]          rsp_prize_total,
   output logic [cpq_pkg::COUNT_W-1:0]          rsp_hack_total,
   output logic                                 rsp_coin_accepted,
   output logic                                 rsp_prize_accepted,
   output logic                                 rsp_hack_alert,
   output logic                                 rsp_coin_out_level,
   output logic                                 rsp_prize_out_level,
   output logic [cpq_pkg::PEND_W-1:0]           rsp_toggles_pending,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [cpq_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  logic [cpq_pkg::CSR_DATA_W-1:0]       csr_wdata
);
   import cpq_pkg::*;

   cfg_type cfg;

   // Input register.
   logic                 stage_valid_ff;
   func_type             func_ff;
   logic                 level_ff;
   logic [TIME_W-1:0]    now_ff;
   logic [CREDIT_W-1:0]  credit_ff;

   // Event state.
   logic                 coin_last_ff, coin_last_in;
   logic [TIME_W-1:0]    coin_time_ff, coin_time_in;
   logic [1:0]           hack_rpt_ff, hack_rpt_in;
   logic                 prize_last_ff, prize_last_in;
   logic [TIME_W-1:0]    prize_time_ff, prize_time_in;
   logic [COUNT_W-1:0]   coin_cnt_ff, coin_cnt_in;
   logic [COUNT_W-1:0]   prize_cnt_ff, prize_cnt_in;
   logic [COUNT_W-1:0]   hack_cnt_ff, hack_cnt_in;
   logic [PEND_W-1:0]    pending_ff, pending_in;
   logic                 coin_out_ff, coin_out_in;
   logic                 prize_out_ff, prize_out_in;

   // Response register.
   logic                 rsp_valid_ff;
   logic                 coin_acc_ff, coin_acc_in;
   logic                 prize_acc_ff, prize_acc_in;
   logic                 alert_ff, alert_in;

   logic                 advance;
   logic                 take;
   logic [TIME_W-1:0]    coin_span;
   logic [TIME_W-1:0]    prize_span;
   logic                 coin_width_ok;
   logic                 prize_width_ok;
   logic                 hack_hit;
   logic [PEND_W:0]      pend_sum;
   logic [PEND_W-1:0]    pend_add;
   logic [PEND_W-1:0]    pend_sat;
   logic [1:0]           hack_rpt_inc;

   cpq_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   assign csr_ready = 1'b1;

   // The response register frees up when it is empty or being read; the input
   // register frees up when it is empty or moving into the response register.
   assign advance   = !rsp_valid_ff || rsp_ready;
   assign take      = stage_valid_ff && advance;
   assign req_ready = !stage_valid_ff || advance;

   // Modular time differences; a wrap of the millisecond clock is harmless.
   assign coin_span  = now_ff - coin_time_ff;
   assign prize_span = now_ff - prize_time_ff;
   assign coin_width_ok  = (coin_span > {16'd0, cfg.coin_min}) &&
                           (coin_span < {16'd0, cfg.coin_max});
   assign prize_width_ok = (prize_span > {16'd0, cfg.prize_min}) &&
                           (prize_span < {16'd0, cfg.prize_max});
   assign hack_hit       = coin_span < {16'd0, cfg.hack_gap};
   assign hack_rpt_inc   = hack_rpt_ff + 2'd1;

   // A coin adds two toggles; a credit word adds twice its count.
   assign pend_add = (func_ff == FUNC_COIN) ? PEND_W'(2) :
                     {{(PEND_W-CREDIT_W-1){1'b0}}, credit_ff, 1'b0};
   assign pend_sum = {1'b0, pending_ff} + {1'b0, pend_add};
   assign pend_sat = pend_sum[PEND_W] ? PENDING_MAX : pend_sum[PEND_W-1:0];

   always_comb begin
      coin_last_in  = coin_last_ff;
      coin_time_in  = coin_time_ff;
      hack_rpt_in   = hack_rpt_ff;
      prize_last_in = prize_last_ff;
      prize_time_in = prize_time_ff;
      coin_cnt_in   = coin_cnt_ff;
      prize_cnt_in  = prize_cnt_ff;
      hack_cnt_in   = hack_cnt_ff;
      pending_in    = pending_ff;
      coin_out_in   = coin_out_ff;
      prize_out_in  = prize_out_ff;
      coin_acc_in   = 1'b0;
      prize_acc_in  = 1'b0;
      alert_in      = 1'b0;
      case (func_ff)
         FUNC_COIN: begin
            if (level_ff != cfg.coin_idle) begin
               // Start of a coin pulse: check how soon it follows the last one.
               if (hack_hit) begin
                  hack_cnt_in = hack_cnt_ff + COUNT_W'(1);
                  if (hack_rpt_inc == HACKS_PER_ALERT) begin
                     hack_rpt_in = 2'd0;
                     alert_in    = 1'b1;
                  end else begin
                     hack_rpt_in = hack_rpt_inc;
                  end
               end
               coin_time_in = now_ff;
            end else if (coin_last_ff != cfg.coin_idle && coin_width_ok) begin
               coin_cnt_in = coin_cnt_ff + COUNT_W'(1);
               coin_acc_in = 1'b1;
               pending_in  = pend_sat;
            end
            coin_last_in = level_ff;
         end
         FUNC_PRIZE: begin
            if (level_ff != cfg.prize_idle) begin
               prize_time_in = now_ff;
            end else if (prize_last_ff != cfg.prize_idle && prize_width_ok) begin
               prize_cnt_in = prize_cnt_ff + COUNT_W'(1);
               prize_acc_in = 1'b1;
            end
            prize_last_in = level_ff;
         end
         FUNC_TICK: begin
            if (pending_ff != '0) begin
               coin_out_in  = !coin_out_ff;
               prize_out_in = !prize_out_ff;
               pending_in   = pending_ff - PEND_W'(1);
            end
         end
         FUNC_CREDIT: begin
            pending_in = pend_sat;
         end
         default: begin
            pending_in = pending_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         coin_last_ff   <= 1'b0;
         coin_time_ff   <= '0;
         hack_rpt_ff    <= '0;
         prize_last_ff  <= 1'b0;
         prize_time_ff  <= '0;
         coin_cnt_ff    <= '0;
         prize_cnt_ff   <= '0;
         hack_cnt_ff    <= '0;
         pending_ff     <= '0;
         coin_out_ff    <= 1'b0;
         prize_out_ff   <= 1'b0;
      end else begin
         if (req_ready) begin
            stage_valid_ff <= req_valid;
         end
         if (take) begin
            rsp_valid_ff  <= 1'b1;
            coin_last_ff  <= coin_last_in;
            coin_time_ff  <= coin_time_in;
            hack_rpt_ff   <= hack_rpt_in;
            prize_last_ff <= prize_last_in;
            prize_time_ff <= prize_time_in;
            coin_cnt_ff   <= coin_cnt_in;
            prize_cnt_ff  <= prize_cnt_in;
            hack_cnt_ff   <= hack_cnt_in;
            pending_ff    <= pending_in;
            coin_out_ff   <= coin_out_in;
            prize_out_ff  <= prize_out_in;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Payload registers carry no reset.
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         func_ff   <= func_type'(req_func);
         level_ff  <= req_pin_level;
         now_ff    <= req_now_ms;
         credit_ff <= req_credit_count;
      end
      if (take) begin
         coin_acc_ff  <= coin_acc_in;
         prize_acc_ff <= prize_acc_in;
         alert_ff     <= alert_in;
      end
   end

   // The totals, pin levels and queue depth in the response word are the event
   // state itself, which only moves when a new word enters the response register.
   assign rsp_valid           = rsp_valid_ff;
   assign rsp_coin_total      = coin_cnt_ff;
   assign rsp_prize_total     = prize_cnt_ff;
   assign rsp_hack_total      = hack_cnt_ff;
   assign rsp_coin_accepted   = coin_acc_ff;
   assign rsp_prize_accepted  = prize_acc_ff;
   assign rsp_hack_alert      = alert_ff;
   assign rsp_coin_out_level  = coin_out_ff;
   assign rsp_prize_out_level = prize_out_ff;
   assign rsp_toggles_pending = pending_ff;

   // Both output pins always toggle together from the same reset level.
   a_pins_in_step: assert property (@(posedge clock) disable iff (reset)
      coin_out_ff == prize_out_ff)
      else $error("coin and prize output pins diverged");

   // The hack report count wraps at three and never rests there.
   a_hack_rpt_range: assert property (@(posedge clock) disable iff (reset)
      hack_rpt_ff != HACKS_PER_ALERT)
      else $error("hack report count reached the alert value");

   // An alert is only raised together with a new hack count.
   a_alert_counts: assert property (@(posedge clock) disable iff (reset)
      take && alert_in |=> hack_cnt_ff == $past(hack_cnt_ff) + COUNT_W'(1))
      else $error("hack alert without a hack count");

   // A single word accepts at most one pulse or raises an alert, never two of these.
   a_flags_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> $onehot0({coin_acc_ff, prize_acc_ff, alert_ff}))
      else $error("more than one event flag in a response word");

   // An accepted coin leaves at least two toggles queued.
   a_coin_queues: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && coin_acc_ff |-> pending_ff >= PEND_W'(2))
      else $error("accepted coin did not queue its toggles");

   // A response word is held while the receiver stalls.
   a_rsp_held: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ready |=> rsp_valid_ff && $stable(coin_cnt_ff) &&
      $stable(pending_ff))
      else $error("response word changed under a stall");

endmodule

>>> test/coin_pulse_qualifier_tb.sv
`timescale 1ns / 100ps

module coin_pulse_qualifier_tb;
   import cpq_pkg::*;

   // Any register index above the last defined one must be ignored by the block.
   localparam logic [CSR_INDEX_W-1:0] CSR_UNUSED = 3'd7;
   localparam int unsigned TOGGLES_PER_COIN = 2;
   // Cycles in which no channel moves a word before the run is declared hung.
   localparam int STALL_LIMIT = 2000;

   // One response word, laid out in port order so the DUT outputs can be
   // packed into it with a single concatenation.
   typedef struct packed {
      logic [COUNT_W-1:0] coin_total;
      logic [COUNT_W-1:0] prize_total;
      logic [COUNT_W-1:0] hack_total;
      logic               coin_accepted;
      logic               prize_accepted;
      logic               hack_alert;
      logic               coin_out_level;
      logic               prize_out_level;
      logic [PEND_W-1:0]  toggles_pending;
   } tally_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_ready;
   logic [1:0]             req_func = FUNC_TICK;
   logic                   req_pin_level = 1'b0;
   logic [TIME_W-1:0]      req_now_ms = '0;
   logic [CREDIT_W-1:0]    req_credit_count = '0;
   logic                   rsp_valid;
   logic                   rsp_ready = 1'b0;
   logic [COUNT_W-1:0]     rsp_coin_total;
   logic [COUNT_W-1:0]     rsp_prize_total;
   logic [COUNT_W-1:0]     rsp_hack_total;
   logic                   rsp_coin_accepted;
   logic                   rsp_prize_accepted;
   logic                   rsp_hack_alert;
   logic                   rsp_coin_out_level;
   logic                   rsp_prize_out_level;
   logic [PEND_W-1:0]      rsp_toggles_pending;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata = '0;

   coin_pulse_qualifier dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_func            (req_func),
      .req_pin_level       (req_pin_level),
      .req_now_ms          (req_now_ms),
      .req_credit_count    (req_credit_count),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_coin_total      (rsp_coin_total),
      .rsp_prize_total     (rsp_prize_total),
      .rsp_hack_total      (rsp_hack_total),
      .rsp_coin_accepted   (rsp_coin_accepted),
      .rsp_prize_accepted  (rsp_prize_accepted),
      .rsp_hack_alert      (rsp_hack_alert),
      .rsp_coin_out_level  (rsp_coin_out_level),
      .rsp_prize_out_level (rsp_prize_out_level),
      .rsp_toggles_pending (rsp_toggles_pending),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_index           (csr_index),
      .csr_wdata           (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ---------------------------------------------------------------------------
   // Shadow copy of the qualifier: configuration plus event state. It is
   // advanced once per accepted request word, in acceptance order.
   // ---------------------------------------------------------------------------
   cfg_type             live_cfg;
   logic                coin_prev_lvl;
   logic                prize_prev_lvl;
   logic [TIME_W-1:0]   coin_edge_ms;
   logic [TIME_W-1:0]   prize_edge_ms;
   logic [1:0]          hack_streak;
   logic [COUNT_W-1:0]  coin_sum;
   logic [COUNT_W-1:0]  prize_sum;
   logic [COUNT_W-1:0]  hack_sum;
   logic [PEND_W-1:0]   toggle_backlog;
   logic                coin_pin_q;
   logic                prize_pin_q;

   // Expected response words, oldest first.
   tally_type tally_q[$];

   int          fail_count = 0;
   int          words_sent = 0;
   int          burst_left = 0;
   int          idle_cycles = 0;
   logic [31:0] wall_ms;

   // A pulse width qualifies only when it lies strictly inside the window.
   // The width is a modular difference, so a pulse that spans the wrap of the
   // millisecond timer is measured correctly.
   function automatic logic in_window(input logic [TIME_W-1:0] width,
                                      input logic [CSR_DATA_W-1:0] lo,
                                      input logic [CSR_DATA_W-1:0] hi);
      return (width > {16'd0, lo}) && (width < {16'd0, hi});
   endfunction

   // The toggle backlog saturates at its all-ones value instead of wrapping.
   function automatic void add_toggles(input logic [31:0] count);
      logic [31:0] sum;
      sum = {16'd0, toggle_backlog} + count;
      toggle_backlog = (sum > {16'd0, PENDING_MAX}) ? PENDING_MAX : sum[PEND_W-1:0];
   endfunction

   // Works out the response word for one request word and advances the shadow
   // state, exactly as the block is required to do.
   function automatic tally_type qualify_word(input func_type f, input logic lvl,
                                              input logic [TIME_W-1:0] now,
                                              input logic [CREDIT_W-1:0] credits);
      tally_type t;
      t = '0;
      case (f)
         FUNC_COIN: begin
            if (lvl != live_cfg.coin_idle) begin
               // Active edge: a too-short gap since the previous active edge is a
               // hack; every third one raises the alert and restarts the streak.
               if (now - coin_edge_ms < {16'd0, live_cfg.hack_gap}) begin
                  hack_sum = hack_sum + COUNT_W'(1);
                  hack_streak = hack_streak + 2'd1;
                  if (hack_streak >= HACKS_PER_ALERT) begin
                     hack_streak = 2'd0;
                     t.hack_alert = 1'b1;
                  end
               end
               coin_edge_ms = now;
            end else if (coin_prev_lvl != live_cfg.coin_idle &&
                         in_window(now - coin_edge_ms, live_cfg.coin_min,
                                   live_cfg.coin_max)) begin
               coin_sum = coin_sum + COUNT_W'(1);
               t.coin_accepted = 1'b1;
               add_toggles(TOGGLES_PER_COIN);
            end
            coin_prev_lvl = lvl;
         end
         FUNC_PRIZE: begin
            if (lvl != live_cfg.prize_idle) begin
               prize_edge_ms = now;
            end else if (prize_prev_lvl != live_cfg.prize_idle &&
                         in_window(now - prize_edge_ms, live_cfg.prize_min,
                                   live_cfg.prize_max)) begin
               prize_sum = prize_sum + COUNT_W'(1);
               t.prize_accepted = 1'b1;
            end
            prize_prev_lvl = lvl;
         end
         FUNC_TICK: begin
            // A tick with nothing queued leaves both pins and the queue alone.
            if (toggle_backlog != '0) begin
               coin_pin_q = ~coin_pin_q;
               prize_pin_q = ~prize_pin_q;
               toggle_backlog = toggle_backlog - PEND_W'(1);
            end
         end
         default: begin
            add_toggles({24'd0, credits} * TOGGLES_PER_COIN);
         end
      endcase
      t.coin_total = coin_sum;
      t.prize_total = prize_sum;
      t.hack_total = hack_sum;
      t.coin_out_level = coin_pin_q;
      t.prize_out_level = prize_pin_q;
      t.toggles_pending = toggle_backlog;
      return t;
   endfunction

   function automatic string show_tally(input tally_type t);
      return $sformatf({"coin=%0d prize=%0d hack=%0d coin_acc=%b prize_acc=%b ",
                        "alert=%b out=%b/%b pending=%0d"},
                       t.coin_total, t.prize_total, t.hack_total, t.coin_accepted,
                       t.prize_accepted, t.hack_alert, t.coin_out_level,
                       t.prize_out_level, t.toggles_pending);
   endfunction

   // Only the first ten failures are printed; the rest are just counted.
   function automatic void note_failure(input string msg);
      fail_count++;
      if (fail_count <= 10)
         $display("%s", msg);
   endfunction

   // ---------------------------------------------------------------------------
   // Channel drivers. Everything is driven at the falling edge, and handshakes
   // are sampled right after the rising edge, before the block's registers move.
   // ---------------------------------------------------------------------------

   // Presents one request word and holds it until the block takes it. Valid is
   // left high, so back-to-back calls form a burst without a bubble.
   task automatic send_word(input func_type f, input logic lvl,
                            input logic [TIME_W-1:0] now,
                            input logic [CREDIT_W-1:0] credits);
      @(negedge clock);
      req_valid = 1'b1;
      req_func = f;
      req_pin_level = lvl;
      req_now_ms = now;
      req_credit_count = credits;
      @(posedge clock);
      while (!req_ready)
         @(posedge clock);
      tally_q.push_back(qualify_word(f, lvl, now, credits));
      words_sent++;
   endtask

   // Bursts of random length separated by random gaps. Some bursts are long
   // and some gaps are empty, so both busy and sparse traffic show up.
   task automatic pace();
      int gap;
      if (burst_left == 0) begin
         burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 60)
                                                  : $urandom_range(1, 12);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap > 0) begin
            @(negedge clock);
            req_valid = 1'b0;
            repeat (gap - 1) @(negedge clock);
         end
      end else begin
         burst_left--;
      end
   endtask

   // Stops sending and waits until every expected response word has come
   // back, which leaves the block idle since every request yields one word.
   task automatic drain();
      @(negedge clock);
      req_valid = 1'b0;
      while (tally_q.size() != 0)
         @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_INDEX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_valid = 1'b1;
      csr_index = idx;
      csr_wdata = data;
      @(posedge clock);
      while (!csr_ready)
         @(posedge clock);
      case (idx)
         CSR_COIN_IDLE:  live_cfg.coin_idle = data[0];
         CSR_PRIZE_IDLE: live_cfg.prize_idle = data[0];
         CSR_COIN_MIN:   live_cfg.coin_min = data;
         CSR_COIN_MAX:   live_cfg.coin_max = data;
         CSR_PRIZE_MIN:  live_cfg.prize_min = data;
         CSR_PRIZE_MAX:  live_cfg.prize_max = data;
         CSR_HACK_GAP:   live_cfg.hack_gap = data;
         default: ;
      endcase
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   // Rewrites every register once the block has gone idle. A write to the
   // unused index goes along with it and must change nothing.
   task automatic apply_setting(input logic coin_idle, input logic prize_idle,
                                input logic [15:0] coin_min, input logic [15:0] coin_max,
                                input logic [15:0] prize_min,
                                input logic [15:0] prize_max,
                                input logic [15:0] hack_gap);
      drain();
      write_reg(CSR_COIN_IDLE, {15'($urandom), coin_idle});
      write_reg(CSR_PRIZE_IDLE, {15'($urandom), prize_idle});
      write_reg(CSR_COIN_MIN, coin_min);
      write_reg(CSR_COIN_MAX, coin_max);
      write_reg(CSR_PRIZE_MIN, prize_min);
      write_reg(CSR_PRIZE_MAX, prize_max);
      write_reg(CSR_HACK_GAP, hack_gap);
      write_reg(CSR_UNUSED, CSR_DATA_W'($urandom));
   endtask

   // Widths cluster on the window edges, where an off-by-one would show.
   function automatic logic [31:0] pick_width(input logic [15:0] lo, input logic [15:0] hi);
      logic [31:0] lo32;
      logic [31:0] hi32;
      lo32 = {16'd0, lo};
      hi32 = {16'd0, hi};
      case ($urandom_range(0, 5))
         0: return lo32;
         1: return lo32 + 1;
         2: return hi32 - 1;
         3: return hi32;
         4: return $urandom_range(lo32, hi32);
         default: return $urandom_range(0, 70000);
      endcase
   endfunction

   // One well-formed pulse on a random pin: active edge, maybe a tick in the
   // middle, then the return to idle. Coin pulses sometimes start soon enough
   // after the last one to count as tampering.
   task automatic emit_pulse();
      logic        on_coin;
      logic        idle;
      logic [31:0] start;
      logic [31:0] width;
      on_coin = 1'($urandom_range(0, 1));
      idle = on_coin ? live_cfg.coin_idle : live_cfg.prize_idle;
      if (on_coin && $urandom_range(0, 2) == 0)
         start = wall_ms + $urandom_range(0, live_cfg.hack_gap + 2);
      else
         start = wall_ms + $urandom_range(0, 5000);
      width = on_coin ? pick_width(live_cfg.coin_min, live_cfg.coin_max)
                      : pick_width(live_cfg.prize_min, live_cfg.prize_max);
      send_word(on_coin ? FUNC_COIN : FUNC_PRIZE, ~idle, start, 8'($urandom));
      pace();
      if ($urandom_range(0, 3) == 0) begin
         send_word(FUNC_TICK, 1'($urandom), $urandom, 8'($urandom));
         pace();
      end
      send_word(on_coin ? FUNC_COIN : FUNC_PRIZE, idle, start + width, 8'($urandom));
      pace();
      wall_ms = start + width;
   endtask

   // Random traffic for one configuration. Most words are pulses; the rest are
   // ticks, credit requests, bursts of coin bounce and unstructured noise.
   // Halfway through, the sender holds off until every response is back.
   task automatic drive_traffic(input int count, input bit big_credits);
      int          stop;
      int          half;
      int          pick;
      int          bounces;
      logic [7:0]  credits;
      bit          paused;
      stop = words_sent + count;
      half = words_sent + count / 2;
      paused = 1'b0;
      while (words_sent < stop) begin
         if (!paused && words_sent >= half) begin
            drain();
            paused = 1'b1;
         end
         pick = $urandom_range(0, 99);
         if (pick < 45) begin
            emit_pulse();
         end else if (pick < 65) begin
            send_word(FUNC_TICK, 1'($urandom), $urandom, 8'($urandom));
            pace();
         end else if (pick < 75) begin
            credits = big_credits ? 8'($urandom) : 8'($urandom_range(0, 2));
            send_word(FUNC_CREDIT, 1'($urandom), $urandom, credits);
            pace();
         end else if (pick < 85) begin
            // A bouncing coin contact: several active edges close together,
            // then a single release.
            bounces = $urandom_range(1, 4);
            repeat (bounces) begin
               wall_ms = wall_ms + $urandom_range(0, live_cfg.hack_gap + 3);
               send_word(FUNC_COIN, ~live_cfg.coin_idle, wall_ms, 8'($urandom));
               pace();
            end
            wall_ms = wall_ms + pick_width(live_cfg.coin_min, live_cfg.coin_max);
            send_word(FUNC_COIN, live_cfg.coin_idle, wall_ms, 8'($urandom));
            pace();
         end else begin
            send_word(func_type'($urandom_range(0, 2)), 1'($urandom), $urandom,
                      8'($urandom));
            pace();
         end
      end
   endtask

   // ---------------------------------------------------------------------------
   // Tests.
   // ---------------------------------------------------------------------------

   // Right after reset both last levels are 0 and both active times are 0, so
   // with the default idle level of 1 a release at 50 ms qualifies at once.
   // The two ticks use up the coin's toggles and the third finds none queued.
   task automatic test_after_reset();
      send_word(FUNC_COIN, 1'b1, 32'd50, 8'd0);
      send_word(FUNC_PRIZE, 1'b1, 32'd50, 8'hFF);
      send_word(FUNC_TICK, 1'b0, 32'hFFFF_FFFF, 8'hFF);
      send_word(FUNC_TICK, 1'b1, 32'd0, 8'd0);
      send_word(FUNC_TICK, 1'b0, 32'd0, 8'd0);
   endtask

   // Window edges with the default 20..120 ms window, pulses across the timer
   // wrap, a repeated release, and three close active edges raising the alert.
   task automatic test_pulse_edges();
      logic [31:0] t0;
      t0 = 32'hFFFF_FF00;
      send_word(FUNC_COIN, 1'b0, t0, 8'd7);
      send_word(FUNC_COIN, 1'b1, t0 + 20, 8'd0);
      send_word(FUNC_COIN, 1'b0, t0 + 200, 8'd0);
      send_word(FUNC_COIN, 1'b1, t0 + 221, 8'd0);
      send_word(FUNC_COIN, 1'b0, t0 + 400, 8'd0);
      send_word(FUNC_COIN, 1'b1, t0 + 519, 8'd0);
      send_word(FUNC_COIN, 1'b0, t0 + 700, 8'd0);
      send_word(FUNC_COIN, 1'b1, t0 + 820, 8'd0);
      send_word(FUNC_COIN, 1'b1, t0 + 830, 8'd0);
      send_word(FUNC_COIN, 1'b0, t0 + 860, 8'd0);
      send_word(FUNC_COIN, 1'b0, t0 + 870, 8'd0);
      send_word(FUNC_COIN, 1'b0, t0 + 880, 8'd0);
      send_word(FUNC_COIN, 1'b0, t0 + 890, 8'd0);
      send_word(FUNC_COIN, 1'b1, t0 + 900, 8'd0);
      send_word(FUNC_PRIZE, 1'b0, 32'hFFFF_FFFF, 8'd0);
      send_word(FUNC_PRIZE, 1'b1, 32'd20, 8'd0);
      send_word(FUNC_PRIZE, 1'b0, 32'd0, 8'd0);
      send_word(FUNC_PRIZE, 1'b1, 32'd1, 8'd0);
      send_word(FUNC_CREDIT, 1'b1, 32'hFFFF_FFFF, 8'd255);
      send_word(FUNC_CREDIT, 1'b0, 32'd0, 8'd0);
      send_word(FUNC_TICK, 1'b1, 32'd0, 8'd0);
   endtask

   // Several settings, including both idle levels, the widest window, an
   // empty window with the hack gap at its maximum, and random settings.
   task automatic test_random_traffic();
      logic [15:0] cmin;
      logic [15:0] pmin;
      wall_ms = $urandom;
      apply_setting(1'b1, 1'b1, RST_WIDTH_MIN, RST_WIDTH_MAX, RST_WIDTH_MIN,
                    RST_WIDTH_MAX, RST_HACK_GAP);
      drive_traffic(130, 1'b0);
      apply_setting(1'b0, 1'b0, 16'd0, 16'hFFFF, 16'd0, 16'hFFFF, 16'd0);
      drive_traffic(130, 1'b0);
      apply_setting(1'b1, 1'b0, 16'hFFFF, 16'd0, 16'hFFFF, 16'd0, 16'hFFFF);
      drive_traffic(110, 1'b0);
      apply_setting(1'b0, 1'b1, 16'd100, 16'd3000, 16'd5, 16'd40, 16'd500);
      drive_traffic(130, 1'b0);
      repeat (2) begin
         cmin = 16'($urandom_range(0, 300));
         pmin = 16'($urandom_range(0, 300));
         apply_setting(1'($urandom), 1'($urandom), cmin,
                       16'(cmin + $urandom_range(0, 600)),
                       pmin, 16'(pmin + $urandom_range(0, 600)),
                       16'($urandom_range(0, 200)));
         drive_traffic(130, 1'b0);
      end
      drive_traffic(60, 1'b1);
   endtask

   // 132 requests of 255 credits overfill the 16-bit queue whatever it held
   // before; a tick and a further credit then check that it sticks at the top.
   task automatic test_queue_saturation();
      repeat (132) begin
         send_word(FUNC_CREDIT, 1'($urandom), $urandom, 8'd255);
         pace();
      end
      send_word(FUNC_TICK, 1'($urandom), $urandom, 8'($urandom));
      send_word(FUNC_CREDIT, 1'($urandom), $urandom, 8'd1);
      send_word(FUNC_TICK, 1'($urandom), $urandom, 8'($urandom));
   endtask

   // ---------------------------------------------------------------------------
   // Response side.
   // ---------------------------------------------------------------------------

   // The receiver follows a ready pattern from a 16-bit mask that is redrawn
   // periodically. A quarter of the patterns never stall, and every other pattern
   // has at least one ready cycle so the block always makes progress.
   logic [15:0] stall_mask = 16'hFFFF;
   logic [3:0]  open_slot;
   int unsigned stall_tick = 0;

   always @(negedge clock) begin
      stall_tick = stall_tick + 1;
      if (stall_tick % 96 == 0) begin
         if ($urandom_range(0, 3) == 0) begin
            stall_mask = 16'hFFFF;
         end else begin
            stall_mask = 16'($urandom);
            open_slot = 4'($urandom_range(0, 15));
            stall_mask[open_slot] = 1'b1;
         end
      end
      rsp_ready = stall_mask[stall_tick[3:0]];
   end

   // Each accepted response word is checked field by field against the oldest
   // expectation.
   tally_type seen;
   tally_type want;
   string     diff;

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         seen = {rsp_coin_total, rsp_prize_total, rsp_hack_total, rsp_coin_accepted,
                 rsp_prize_accepted, rsp_hack_alert, rsp_coin_out_level,
                 rsp_prize_out_level, rsp_toggles_pending};
         if (tally_q.size() == 0) begin
            note_failure({"response word with nothing expected: ", show_tally(seen)});
         end else begin
            want = tally_q.pop_front();
            diff = "";
            if (seen.coin_total !== want.coin_total) diff = {diff, " coin_total"};
            if (seen.prize_total !== want.prize_total) diff = {diff, " prize_total"};
            if (seen.hack_total !== want.hack_total) diff = {diff, " hack_total"};
            if (seen.coin_accepted !== want.coin_accepted) diff = {diff, " coin_accepted"};
            if (seen.prize_accepted !== want.prize_accepted)
               diff = {diff, " prize_accepted"};
            if (seen.hack_alert !== want.hack_alert) diff = {diff, " hack_alert"};
            if (seen.coin_out_level !== want.coin_out_level)
               diff = {diff, " coin_out_level"};
            if (seen.prize_out_level !== want.prize_out_level)
               diff = {diff, " prize_out_level"};
            if (seen.toggles_pending !== want.toggles_pending)
               diff = {diff, " toggles_pending"};
            if (diff != "")
               note_failure($sformatf("mismatch at %0t on%s\n  expected %s\n  actual   %s",
                                      $time, diff, show_tally(want), show_tally(seen)));
         end
      end
   end

   // Hang detection: count cycles in which no channel moves a word.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_valid && csr_ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
   end

   initial begin
      while (idle_cycles < STALL_LIMIT)
         @(posedge clock);
      $display("timeout: no word moved for %0d cycles", STALL_LIMIT);
      $display("TB_ERROR");
      $finish;
   end

   // ---------------------------------------------------------------------------
   // Main sequence.
   // ---------------------------------------------------------------------------
   initial begin
      // Shadow state matches the block's reset state.
      live_cfg.coin_idle = 1'b1;
      live_cfg.prize_idle = 1'b1;
      live_cfg.coin_min = RST_WIDTH_MIN;
      live_cfg.coin_max = RST_WIDTH_MAX;
      live_cfg.prize_min = RST_WIDTH_MIN;
      live_cfg.prize_max = RST_WIDTH_MAX;
      live_cfg.hack_gap = RST_HACK_GAP;
      coin_prev_lvl = 1'b0;
      prize_prev_lvl = 1'b0;
      coin_edge_ms = '0;
      prize_edge_ms = '0;
      hack_streak = '0;
      coin_sum = '0;
      prize_sum = '0;
      hack_sum = '0;
      toggle_backlog = '0;
      coin_pin_q = 1'b0;
      prize_pin_q = 1'b0;

      reset = 1'b1;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_after_reset();
      test_pulse_edges();
      test_random_traffic();
      test_queue_saturation();

      // Let the pipeline settle so a stray extra response word is caught.
      drain();
      repeat (8) @(posedge clock);
      if (fail_count == 0 && tally_q.size() == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule
